// ===== src/dtcb_pkg.sv =====
// Types, constants and coefficient tables for the depth colormap blend unit.
// No dependencies.
`default_nettype none

package dtcb_pkg;

  localparam int CFG_W = 32;
  localparam int ACC_W = 27;
  localparam int NUM_CH = 3;
  localparam int NUM_COEF = 6;
  localparam logic [8:0] ALPHA_ONE = 9'd256;

  typedef enum logic [1:0] {
    REG_RANGE_LOW   = 2'd0,
    REG_INV_SPAN    = 2'd1,
    REG_BLEND_ALPHA = 2'd2
  } cfg_reg_e;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [NUM_CH-1:0][7:0] rgb_t;

  typedef struct packed {
    logic signed [31:0] depth_value;
    logic [7:0]         pixel_red;
    logic [7:0]         pixel_green;
    logic [7:0]         pixel_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_word_t;

  // Turbo polynomial coefficients, Q8.16, constant term first; red, green, blue.
  localparam acc_t COEF [NUM_CH][NUM_COEF] = '{
    '{ 27'sd8895, 27'sd302474, -27'sd2795787, 27'sd8659343, -27'sd10023233, 27'sd3885392 },
    '{ 27'sd5990, 27'sd143798, 27'sd317389, -27'sd929630, 27'sd280317, 27'sd185438 },
    '{ 27'sd6991, 27'sd828503, -27'sd3970305, 27'sd7232734, -27'sd5891890, 27'sd1792295 }
  };

endpackage

`default_nettype wire

// ===== src/dtcb_stream_if.sv =====
// Valid/ready stream interface carrying one word per handshake.
// The word type is given per instance, normally from dtcb_pkg.
`default_nettype none

interface dtcb_stream_if #(
  parameter type word_t = logic
) ();

  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== src/depth_turbo_colormap_blend_unit.sv =====
// Depth to Turbo colormap with alpha blend onto the camera pixel.
// Pipeline: depth offset, span scaling, Horner steps, colour clamp, alpha blend.
// Throughput: one word per cycle; every stage holds its own valid bit and
// stalls only when it is full and the stage after it cannot take a word.
// Reset: asynchronous, clears all valid bits and loads the register defaults.
// Depends on dtcb_pkg and dtcb_stream_if.
`default_nettype none

module depth_turbo_colormap_blend_unit
  import dtcb_pkg::*;
#(
  parameter int NORM_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  dtcb_stream_if.sink           in_i,
  dtcb_stream_if.source         out_o
);

  localparam int NSTG  = 9;
  localparam int TW    = NORM_BITS + 1;
  localparam int SHW   = 32 + NORM_BITS;
  localparam int PW    = ACC_W + NORM_BITS + 2;
  localparam int NHORN = NUM_COEF - 1;
  localparam logic [SHW-1:0] T_ONE = SHW'(1) << NORM_BITS;

  // configuration registers
  logic signed [31:0] range_low_q;
  logic [31:0]        inv_span_q;
  logic [8:0]         alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q <= 32'sd0;
      inv_span_q  <= 32'd65536;
      alpha_q     <= 9'd166;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_RANGE_LOW:   range_low_q <= cfg_data_i;
        REG_INV_SPAN:    inv_span_q  <= cfg_data_i;
        REG_BLEND_ALPHA: alpha_q     <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // stage flow control
  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = out_o.ready;
    for (int s = NSTG - 1; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
  end

  assign in_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_i.valid;
      for (int s = 1; s < NSTG; s++) begin
        if (rdy[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // pixel carried alongside, stages 0..7
  rgb_t pix_q [NSTG-1];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) pix_q[0] <= {in_i.data.pixel_red, in_i.data.pixel_green, in_i.data.pixel_blue};
    for (int s = 1; s < NSTG - 1; s++) begin
      if (rdy[s]) pix_q[s] <= pix_q[s-1];
    end
  end

  // stage 0: depth minus lower bound
  logic signed [32:0] diff;
  logic [31:0]        diff_q;
  logic               pos_q;

  assign diff = $signed({in_i.data.depth_value[31], in_i.data.depth_value})
              - $signed({range_low_q[31], range_low_q});

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      diff_q <= diff[31:0];
      pos_q  <= !diff[32] && (|diff[31:0]);
    end
  end

  // stage 1: scale by inverse span, truncate and clamp to one; zero when not positive
  logic [63:0]    span_prod;
  logic [SHW-1:0] span_sh;
  logic [TW-1:0]  t_d;
  logic [TW-1:0]  t_q [1:NHORN];

  assign span_prod = 64'(diff_q) * 64'(inv_span_q);
  assign span_sh   = span_prod[63:32-NORM_BITS];

  always_comb begin
    if (!pos_q) begin
      t_d = '0;
    end else if (span_sh > T_ONE) begin
      t_d = T_ONE[TW-1:0];
    end else begin
      t_d = span_sh[TW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) t_q[1] <= t_d;
    for (int s = 2; s <= NHORN; s++) begin
      if (rdy[s]) t_q[s] <= t_q[s-1];
    end
  end

  // stages 2..6: one Horner step per stage for each channel
  acc_t acc_q [NHORN][NUM_CH];

  for (genvar h = 0; h < NHORN; h++) begin : g_horner
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
      acc_t                 a_in;
      logic signed [PW-1:0] prod;
      logic signed [PW-1:0] prod_sh;
      acc_t                 acc_d;

      if (h == 0) begin : g_first
        assign a_in = COEF[ch][NUM_COEF-1];
      end else begin : g_next
        assign a_in = acc_q[h-1][ch];
      end

      assign prod    = PW'(a_in) * PW'($signed({1'b0, t_q[h+1]}));
      assign prod_sh = prod >>> NORM_BITS;
      assign acc_d   = COEF[ch][NHORN-1-h] + prod_sh[ACC_W-1:0];

      always_ff @(posedge clk_i) begin
        if (rdy[h+2]) acc_q[h][ch] <= acc_d;
      end
    end
  end

  // stage 7: clamp to [0, 1] and scale to 0..255
  // coefficient rows run red first, while rgb_t keeps red in the top byte
  rgb_t col_q;

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_col
    acc_t        a_fin;
    logic [16:0] c_sat;
    logic [24:0] c_mul;

    assign a_fin = acc_q[NHORN-1][ch];

    always_comb begin
      if (a_fin[ACC_W-1]) begin
        c_sat = '0;
      end else if (a_fin > acc_t'(65536)) begin
        c_sat = 17'd65536;
      end else begin
        c_sat = a_fin[16:0];
      end
    end

    assign c_mul = {c_sat, 8'd0} - {8'd0, c_sat};

    always_ff @(posedge clk_i) begin
      if (rdy[NSTG-2]) col_q[NUM_CH-1-ch] <= c_mul[23:16];
    end
  end

  // stage 8: alpha blend
  logic [8:0] a_sat;
  logic [8:0] a_inv;
  rgb_t       out_q;

  assign a_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign a_inv = ALPHA_ONE - a_sat;

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_blend
    logic [16:0] mix;

    assign mix = 17'(pix_q[NSTG-2][ch]) * 17'(a_inv) + 17'(col_q[ch]) * 17'(a_sat);

    always_ff @(posedge clk_i) begin
      if (rdy[NSTG-1]) out_q[ch] <= mix[15:8];
    end
  end

  assign out_o.valid          = v_q[NSTG-1];
  assign out_o.data.out_red   = out_q[2];
  assign out_o.data.out_green = out_q[1];
  assign out_o.data.out_blue  = out_q[0];

`ifndef ASSERT_OFF
  a_in_ready_on_bubble : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(&v_q) || out_o.ready) |-> in_i.ready)
    else $error("input stalled with room in the pipeline");

  a_stage_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((v_q & $past(v_q & ~rdy[NSTG:1])) == $past(v_q & ~rdy[NSTG:1])))
    else $error("stalled stage dropped its word");

  a_t_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (SHW'(t_q[1]) <= T_ONE))
    else $error("normalized depth above one");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_depth_turbo_colormap_blend_unit.sv =====
`timescale 1ns / 100ps
// Testbench for depth_turbo_colormap_blend_unit: random and directed pixel words.
// Checks against a Turbo colormap blend predictor; needs dtcb_pkg and dtcb_stream_if.

module tb_depth_turbo_colormap_blend_unit;
  import dtcb_pkg::*;

  localparam int         PIPE_LATENCY = 9;
  localparam int         NORM         = 16;
  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam int         NUM_PHASES   = 8;
  localparam int         PHASE_WORDS  = 100;

  // Q8.16 Turbo coefficients, constant term first
  localparam longint TURBO_COEF [3][6] = '{
    '{ 8895, 302474, -2795787, 8659343, -10023233, 3885392 },
    '{ 5990, 143798, 317389, -929630, 280317, 185438 },
    '{ 6991, 828503, -3970305, 7232734, -5891890, 1792295 }
  };

  class overlay_checker;
    logic signed [31:0] range_low = 32'sd0;
    logic [31:0]        inv_span  = 32'd65536;
    logic [8:0]         alpha     = 9'd166;
    out_word_t          pending_pixels[$];
    int                 errors  = 0;
    int                 checked = 0;

    function void set_reg(logic [1:0] idx, logic [31:0] d);
      case (idx)
        REG_RANGE_LOW:   range_low = d;
        REG_INV_SPAN:    inv_span  = d;
        REG_BLEND_ALPHA: alpha     = d[8:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] turbo_level(int ch, longint t);
      longint acc;
      acc = TURBO_COEF[ch][5];
      for (int k = 4; k >= 0; k--) acc = TURBO_COEF[ch][k] + ((acc * t) >>> NORM);
      if (acc < 0) acc = 0;
      if (acc > 65536) acc = 65536;
      return 8'((acc * 255) >>> 16);
    endfunction

    function logic [7:0] mix(logic [7:0] pix, logic [7:0] col, int a);
      int v;
      v = (int'(pix) * (256 - a) + int'(col) * a) >> 8;
      return v[7:0];
    endfunction

    function out_word_t blend_pixel(in_word_t w);
      longint          diff;
      longint unsigned prod;
      longint          t;
      int              a;
      out_word_t       r;
      diff = longint'(w.depth_value) - longint'(range_low);
      t = 0;
      if (diff > 0) begin
        prod = diff;
        prod = prod * inv_span;
        t = prod >> (32 - NORM);
        if (t > (64'd1 << NORM)) t = 64'd1 << NORM;
      end
      a = (alpha > ALPHA_ONE) ? 256 : int'(alpha);
      r.out_red   = mix(w.pixel_red,   turbo_level(0, t), a);
      r.out_green = mix(w.pixel_green, turbo_level(1, t), a);
      r.out_blue  = mix(w.pixel_blue,  turbo_level(2, t), a);
      return r;
    endfunction

    function void note_pixel(in_word_t w);
      pending_pixels = {pending_pixels, blend_pixel(w)};
    endfunction

    function void check_pixel(out_word_t got);
      out_word_t exp_w;
      if (pending_pixels.size() == 0) begin
        $error("output word with no pending pixel: %h", got);
        errors++;
        return;
      end
      exp_w = pending_pixels.pop_front();
      checked++;
      if (got.out_red !== exp_w.out_red) begin
        $error("out_red: expected %0d, got %0d", exp_w.out_red, got.out_red);
        errors++;
      end
      if (got.out_green !== exp_w.out_green) begin
        $error("out_green: expected %0d, got %0d", exp_w.out_green, got.out_green);
        errors++;
      end
      if (got.out_blue !== exp_w.out_blue) begin
        $error("out_blue: expected %0d, got %0d", exp_w.out_blue, got.out_blue);
        errors++;
      end
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  dtcb_stream_if #(.word_t(in_word_t))  in_if ();
  dtcb_stream_if #(.word_t(out_word_t)) out_if ();

  depth_turbo_colormap_blend_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  overlay_checker chk;
  bit             no_gaps = 1'b0;
  int             stall_left = 0;
  int             settings_seen = 0;

  always #4 clk_i = ~clk_i;

  // receiver with random stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else if (out_if.valid && out_if.ready) begin
      stall_left = no_gaps ? 0 : $urandom_range(0, 3);
      out_if.ready <= (stall_left == 0);
    end else if (!out_if.ready) begin
      if (stall_left > 0) stall_left--;
      out_if.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) chk.note_pixel(in_if.data);
      if (out_if.valid && out_if.ready) chk.check_pixel(out_if.data);
    end
  end

  task automatic send_word(in_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_pixel(logic [31:0] depth, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_word_t w;
    w.depth_value = depth;
    w.pixel_red   = r;
    w.pixel_green = g;
    w.pixel_blue  = b;
    send_word(w);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (chk.pending() != 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    chk.set_reg(idx, d);
  endtask

  task automatic apply_setting(logic [31:0] rl, logic [31:0] span, logic [31:0] ad,
                               bit poke_unused);
    drain();
    write_reg(REG_RANGE_LOW, rl);
    write_reg(REG_INV_SPAN, span);
    write_reg(REG_BLEND_ALPHA, ad);
    if (poke_unused) write_reg(REG_UNUSED, $urandom);
    cfg_we_i <= 1'b0;
    settings_seen++;
  endtask

  // mostly depths near the mapped window, the rest anywhere
  function automatic logic [31:0] pick_depth();
    longint lim;
    longint d;
    int     sel;
    sel = $urandom_range(0, 9);
    if (sel < 3 || chk.inv_span == 0) return $urandom;
    lim = (64'd1 << 32) / chk.inv_span;
    if (sel == 3)
      d = longint'(chk.range_low) + lim + $urandom_range(0, 2) - 1;
    else if (sel == 4)
      d = longint'(chk.range_low) + $urandom_range(0, 2) - 1;
    else
      d = longint'(chk.range_low) - lim / 8 + longint'($urandom) % (lim + lim / 4 + 1);
    if (d > 64'sh7FFF_FFFF) d = 64'sh7FFF_FFFF;
    if (d < -64'sh8000_0000) d = -64'sh8000_0000;
    return d[31:0];
  endfunction

  function automatic logic [31:0] pick_range_low();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 6))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd65536;
      3:       return $urandom;
      default: return (32'd1 << $urandom_range(8, 22)) + $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [31:0] pick_alpha();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'd256;
      2:       return $urandom_range(257, 511);
      3:       return $urandom;
      default: return $urandom_range(0, 256);
    endcase
  endfunction

  initial begin
    chk = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: window edges and saturation
    send_pixel(32'h8000_0000, 8'd0,   8'd0,   8'd0);
    send_pixel(32'h7FFF_FFFF, 8'd255, 8'd255, 8'd255);
    send_pixel(32'd0,         8'd255, 8'd0,   8'd255);
    send_pixel(32'd1,         8'd0,   8'd255, 8'd0);
    send_pixel(32'd32768,     8'd128, 8'd64,  8'd32);
    send_pixel(32'd65535,     8'd255, 8'd255, 8'd0);
    send_pixel(32'd65536,     8'd0,   8'd128, 8'd255);
    send_pixel(32'd65537,     8'd17,  8'd200, 8'd99);

    // alpha zero, one, and above one
    apply_setting(32'd0, 32'd65536, 32'd0, 1'b0);
    send_pixel(32'd32768, 8'd255, 8'd0, 8'd127);
    apply_setting(32'd0, 32'd65536, 32'd256, 1'b0);
    send_pixel(32'd16384, 8'd0, 8'd255, 8'd127);
    apply_setting(32'd0, 32'd65536, 32'd300, 1'b0);
    send_pixel(32'd49152, 8'd255, 8'd255, 8'd255);
    apply_setting(32'd0, 32'd65536, 32'hFFFF_FFFF, 1'b0);
    send_pixel(32'd40000, 8'd0, 8'd0, 8'd0);

    // zero span, then widest products at the signed extremes
    apply_setting(32'hFFFF_0000, 32'd0, 32'd128, 1'b1);
    send_pixel(32'h7FFF_FFFF, 8'd200, 8'd100, 8'd50);
    send_pixel(32'd0, 8'd10, 8'd20, 8'd30);
    apply_setting(32'h8000_0000, 32'hFFFF_FFFF, 32'd200, 1'b0);
    send_pixel(32'h7FFF_FFFF, 8'd1, 8'd2, 8'd3);
    send_pixel(32'h8000_0000, 8'd4, 8'd5, 8'd6);
    send_pixel(32'h8000_0001, 8'd7, 8'd8, 8'd9);
    apply_setting(32'h7FFF_FFFF, 32'd1, 32'd166, 1'b1);
    send_pixel(32'h8000_0000, 8'd250, 8'd251, 8'd252);
    send_pixel(32'h7FFF_FFFF, 8'd253, 8'd254, 8'd255);

    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_setting(pick_range_low(), pick_span(), pick_alpha(), ($urandom_range(0, 3) == 0));
      no_gaps = (p == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 2 && i == PHASE_WORDS / 2) begin
          in_if.valid <= 1'b0;
          do @(posedge clk_i); while (chk.pending() != 0);
        end
        send_pixel(pick_depth(), $urandom, $urandom, $urandom);
      end
    end

    drain();
    $display("checked %0d blended pixels over %0d register settings,", chk.checked,
             settings_seen + 1);
    $display("including alpha saturation, zero and full span, and signed range extremes");
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
